/* src/assert_macros.svh */
// Assertion helpers shared by the synapse RTL.
// Each macro wraps one clocked property that is disabled while the active-low reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dual exponential synapse assertion failed");

// Next-cycle implication.
`define DES_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dual exponential synapse assertion failed");

`endif

/* src/des_pkg.sv */
// ----------------------------------------------------------------------------
// des_pkg
// Shared types and constants of the dual exponential synapse core.
// ----------------------------------------------------------------------------
`default_nettype none

package des_pkg;

    // Fixed widths of the configuration registers.
    localparam int THR_W  = 16;
    localparam int DLY_W  = 16;
    localparam int REV_W  = 16;
    localparam int FAC_W  = 16;
    localparam int INC_W  = 24;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Register indexes (byte address / 4).
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_THRESHOLD = 3'd0;
    localparam t_reg_idx REG_DELAY     = 3'd1;
    localparam t_reg_idx REG_REVERSAL  = 3'd2;
    localparam t_reg_idx REG_RISE_DEC  = 3'd3;
    localparam t_reg_idx REG_FALL_DEC  = 3'd4;
    localparam t_reg_idx REG_INCREMENT = 3'd5;

    // Configuration seen by the front and the back.
    typedef struct packed {
        logic signed [THR_W-1:0] threshold;
        logic        [DLY_W-1:0] delay;
        logic signed [REV_W-1:0] reversal;
        logic        [FAC_W-1:0] rise_decay;
        logic        [FAC_W-1:0] fall_decay;
        logic        [INC_W-1:0] increment;
    } t_cfg;

    // Sequencer of the back end: one shared multiplier used three times.
    typedef enum logic [2:0] {
        BK_WAIT,
        BK_RISE,
        BK_FALL,
        BK_COND,
        BK_CUR
    } t_back_state;

endpackage

`default_nettype wire

/* src/des_fifo.sv */
// ----------------------------------------------------------------------------
// des_fifo
// Small register queue that decouples the detection front from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module des_fifo #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [AW:0]      r_count, n_count;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    // Pointer and fill count update.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    `DES_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= (AW+1)'(DEPTH))
    `DES_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != '0)

endmodule

`default_nettype wire

/* src/des_front.sv */
// ----------------------------------------------------------------------------
// des_front
// Accepts ticks, runs spike detection and the delay countdown, and tags each
// tick with whether the spike increment lands at its end.
// ----------------------------------------------------------------------------
`default_nettype none

module des_front #(
    parameter int VOLT_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire des_pkg::t_cfg               i_cfg,
    input  wire logic                        i_push,
    input  wire logic signed [VOLT_BITS-1:0] i_pre_voltage,
    input  wire logic signed [VOLT_BITS-1:0] i_post_voltage,
    input  wire logic                        i_q_full,
    output logic                             o_q_push,
    output logic [VOLT_BITS:0]               o_q_data
);

    import des_pkg::*;

    localparam int CMPW = (VOLT_BITS > THR_W) ? VOLT_BITS : THR_W;

    logic               r_ready, n_ready;
    logic               r_pending, n_pending;
    logic [DLY_W-1:0]   r_count, n_count;
    logic               w_accept;
    logic               w_fire;
    logic signed [CMPW-1:0] w_pre;
    logic signed [CMPW-1:0] w_thr;

    assign w_accept = i_push && !i_q_full;
    assign w_pre    = CMPW'(i_pre_voltage);
    assign w_thr    = CMPW'(i_cfg.threshold);

    // Detection first, then the countdown is served for the same tick.
    always_comb begin
        n_ready   = r_ready;
        n_pending = r_pending;
        n_count   = r_count;
        w_fire    = 1'b0;
        if (w_accept) begin
            if (r_ready) begin
                if (w_pre > w_thr) begin
                    n_ready   = 1'b0;
                    n_pending = 1'b1;
                    n_count   = i_cfg.delay;
                end
            end else if (w_pre < w_thr) begin
                n_ready = 1'b1;
            end
            if (n_pending) begin
                if (n_count == '0) begin
                    w_fire    = 1'b1;
                    n_pending = 1'b0;
                end else begin
                    n_count = n_count - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready   <= 1'b1;
            r_pending <= 1'b0;
            r_count   <= '0;
        end else begin
            r_ready   <= n_ready;
            r_pending <= n_pending;
            r_count   <= n_count;
        end
    end

    // Tagged tick into the queue.
    assign o_q_push = w_accept;
    assign o_q_data = {i_post_voltage, w_fire};

endmodule

`default_nettype wire

/* src/des_back.sv */
// ----------------------------------------------------------------------------
// des_back
// Decays both levels and forms the current with one shared multiplier,
// subtracts the levels for conductance, applies the spike increment and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module des_back #(
    parameter int VOLT_BITS       = 16,
    parameter int LEVEL_BITS      = 24,
    parameter int DECAY_FRAC_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire des_pkg::t_cfg                       i_cfg,
    input  wire logic                                i_q_empty,
    input  wire logic [VOLT_BITS:0]                  i_q_data,
    output logic                                     o_q_pop,
    input  wire logic                                i_pop,
    output logic                                     o_empty,
    output logic signed [LEVEL_BITS+VOLT_BITS:0]     o_post_current,
    output logic signed [LEVEL_BITS:0]               o_conductance
);

    import des_pkg::*;

    localparam int DW    = ((VOLT_BITS > REV_W) ? VOLT_BITS : REV_W) + 1;
    localparam int CW    = LEVEL_BITS + 1;
    localparam int CUR_W = LEVEL_BITS + VOLT_BITS + 1;
    localparam int MW    = (CW > DW) ? CW : DW;
    localparam int PW    = 2 * MW;
    localparam int XW    = PW + DECAY_FRAC_BITS;
    localparam int SW    = ((LEVEL_BITS > INC_W) ? LEVEL_BITS : INC_W) + 1;

    t_back_state r_state, n_state;

    logic [LEVEL_BITS-1:0]       r_rise_level, n_rise_level;
    logic [LEVEL_BITS-1:0]       r_fall_level, n_fall_level;
    logic                        r_out_valid, n_out_valid;
    logic signed [VOLT_BITS-1:0] r_post;
    logic                        r_fire;
    logic signed [CW-1:0]        r_cond;
    logic signed [DW-1:0]        r_diff;
    logic signed [CUR_W-1:0]     r_cur_out;
    logic signed [CW-1:0]        r_cond_out;

    logic                        w_out_ok;
    logic                        w_out_load;
    logic signed [MW-1:0]        w_mul_a;
    logic signed [MW-1:0]        w_mul_b;
    logic signed [PW-1:0]        w_prod;
    logic signed [XW-1:0]        w_prod_x;
    logic [LEVEL_BITS-1:0]       w_decayed;
    logic [SW-1:0]               w_rise_sum;
    logic [SW-1:0]               w_fall_sum;
    logic [LEVEL_BITS-1:0]       w_rise_sat;
    logic [LEVEL_BITS-1:0]       w_fall_sat;

    // The result slot frees up when empty or when its beat is taken now.
    assign w_out_ok = !r_out_valid || i_pop;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_WAIT: begin
                if (!i_q_empty) n_state = BK_RISE;
            end
            BK_RISE: n_state = BK_FALL;
            BK_FALL: n_state = BK_COND;
            BK_COND: n_state = BK_CUR;
            BK_CUR: begin
                if (w_out_ok) n_state = i_q_empty ? BK_WAIT : BK_RISE;
            end
            default: n_state = BK_WAIT;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_q_pop    = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            BK_WAIT: o_q_pop = !i_q_empty;
            BK_CUR: begin
                w_out_load = w_out_ok;
                o_q_pop    = w_out_ok && !i_q_empty;
            end
            default: begin
                o_q_pop    = 1'b0;
                w_out_load = 1'b0;
            end
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            BK_RISE: begin
                w_mul_a = signed'(MW'(r_rise_level));
                w_mul_b = signed'(MW'(i_cfg.rise_decay));
            end
            BK_FALL: begin
                w_mul_a = signed'(MW'(r_fall_level));
                w_mul_b = signed'(MW'(i_cfg.fall_decay));
            end
            BK_CUR: begin
                w_mul_a = MW'(r_cond);
                w_mul_b = MW'(r_diff);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod    = PW'(w_mul_a) * PW'(w_mul_b);
    assign w_prod_x  = XW'(w_prod);
    assign w_decayed = w_prod_x[DECAY_FRAC_BITS +: LEVEL_BITS];

    // Saturating spike increment on the decayed levels.
    assign w_rise_sum = SW'(r_rise_level) + SW'(i_cfg.increment);
    assign w_fall_sum = SW'(r_fall_level) + SW'(i_cfg.increment);
    assign w_rise_sat = (w_rise_sum[SW-1:LEVEL_BITS] != '0) ? '1
                                                            : w_rise_sum[LEVEL_BITS-1:0];
    assign w_fall_sat = (w_fall_sum[SW-1:LEVEL_BITS] != '0) ? '1
                                                            : w_fall_sum[LEVEL_BITS-1:0];

    // Level and result-slot update.
    always_comb begin
        n_rise_level = r_rise_level;
        n_fall_level = r_fall_level;
        n_out_valid  = r_out_valid;
        if (i_pop) begin
            n_out_valid = 1'b0;
        end
        if (r_state == BK_RISE) begin
            n_rise_level = w_decayed;
        end
        if (r_state == BK_FALL) begin
            n_fall_level = w_decayed;
        end
        if (w_out_load) begin
            n_out_valid = 1'b1;
            if (r_fire) begin
                n_rise_level = w_rise_sat;
                n_fall_level = w_fall_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_WAIT;
            r_rise_level <= '0;
            r_fall_level <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rise_level <= n_rise_level;
            r_fall_level <= n_fall_level;
            r_out_valid  <= n_out_valid;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_post <= signed'(i_q_data[VOLT_BITS:1]);
            r_fire <= i_q_data[0];
        end
        if (r_state == BK_COND) begin
            r_cond <= signed'(CW'(r_fall_level) - CW'(r_rise_level));
            r_diff <= DW'(r_post) - DW'(i_cfg.reversal);
        end
        if (w_out_load) begin
            r_cur_out  <= w_prod[CUR_W-1:0];
            r_cond_out <= r_cond;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_post_current = r_cur_out;
    assign o_conductance  = r_cond_out;

    `DES_ASSERT_NXT(a_load_sets_valid, i_clk, i_rst_n, w_out_load, r_out_valid)
    `DES_ASSERT_NXT(a_result_held, i_clk, i_rst_n, r_out_valid && !i_pop, r_out_valid)
    `DES_ASSERT_IMP(a_pop_between_ticks, i_clk, i_rst_n, o_q_pop,
                    (r_state == BK_WAIT) || (r_state == BK_CUR))

endmodule

`default_nettype wire

/* src/dual_exponential_synapse_core.sv */
// ----------------------------------------------------------------------------
// dual_exponential_synapse_core
// Dual exponential synapse conductance and current, one tick per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_pre_voltage and i_post_voltage with push; a beat
//   is taken at a clock edge with push high and full low. Result channel:
//   while empty is low, o_post_current and o_conductance hold the oldest
//   result; it is taken at an edge with pop high. Every tick gives exactly
//   one result beat, in order.
//   A taken beat passes through the queue and the back-end states RISE,
//   FALL, COND and CUR before its result reaches the result ports. The
//   back end takes one tick at a time; a single shared multiplier serves
//   both level decays and the current product; COND takes the level difference.
//   A two-entry queue lets detection run ahead of the arithmetic.
//   If the receiver stalls, the result stays on the ports, the back end
//   waits, the queue fills and full rises until pop frees the slot.
//   Reset (synchronous, active low) restores the control and configuration
//   registers, arms detection and clears both levels and the queue.
//   Configuration goes through the APB port at byte address 4*index; write it
//   only while no tick is in flight, as the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_exponential_synapse_core #(
    parameter int VOLT_BITS       = 16,
    parameter int LEVEL_BITS      = 24,
    parameter int DECAY_FRAC_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // Configuration port.
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [des_pkg::ADDR_W-1:0]             paddr,
    input  wire logic [des_pkg::DATA_W-1:0]             pwdata,
    output logic [des_pkg::DATA_W-1:0]                  prdata,
    output logic                                        pready,
    // Tick input.
    input  wire logic                                   push,
    output logic                                        full,
    input  wire logic signed [VOLT_BITS-1:0]            i_pre_voltage,
    input  wire logic signed [VOLT_BITS-1:0]            i_post_voltage,
    // Result output.
    output logic                                        empty,
    input  wire logic                                   pop,
    output logic signed [LEVEL_BITS+VOLT_BITS:0]        o_post_current,
    output logic signed [LEVEL_BITS:0]                  o_conductance
);

    import des_pkg::*;

    t_cfg              r_cfg, n_cfg;
    t_reg_idx          w_idx;
    logic              w_wr;
    logic              w_q_push;
    logic [VOLT_BITS:0] w_q_wdata;
    logic              w_q_full;
    logic              w_q_pop;
    logic [VOLT_BITS:0] w_q_rdata;
    logic              w_q_empty;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;

    // Register writes.
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_THRESHOLD: n_cfg.threshold  = signed'(pwdata[THR_W-1:0]);
                REG_DELAY:     n_cfg.delay      = pwdata[DLY_W-1:0];
                REG_REVERSAL:  n_cfg.reversal   = signed'(pwdata[REV_W-1:0]);
                REG_RISE_DEC:  n_cfg.rise_decay = pwdata[FAC_W-1:0];
                REG_FALL_DEC:  n_cfg.fall_decay = pwdata[FAC_W-1:0];
                REG_INCREMENT: n_cfg.increment  = pwdata[INC_W-1:0];
                default:       n_cfg            = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold  <= '0;
            r_cfg.delay      <= DLY_W'(1);
            r_cfg.reversal   <= '0;
            r_cfg.rise_decay <= '1;
            r_cfg.fall_decay <= '1;
            r_cfg.increment  <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Register reads.
    always_comb begin
        unique case (w_idx)
            REG_THRESHOLD: prdata = DATA_W'(unsigned'(r_cfg.threshold));
            REG_DELAY:     prdata = DATA_W'(r_cfg.delay);
            REG_REVERSAL:  prdata = DATA_W'(unsigned'(r_cfg.reversal));
            REG_RISE_DEC:  prdata = DATA_W'(r_cfg.rise_decay);
            REG_FALL_DEC:  prdata = DATA_W'(r_cfg.fall_decay);
            REG_INCREMENT: prdata = DATA_W'(r_cfg.increment);
            default:       prdata = '0;
        endcase
    end

    des_front #(
        .VOLT_BITS (VOLT_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_push         (push),
        .i_pre_voltage  (i_pre_voltage),
        .i_post_voltage (i_post_voltage),
        .i_q_full       (w_q_full),
        .o_q_push       (w_q_push),
        .o_q_data       (w_q_wdata)
    );

    des_fifo #(
        .WIDTH (VOLT_BITS + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_empty (w_q_empty)
    );

    des_back #(
        .VOLT_BITS       (VOLT_BITS),
        .LEVEL_BITS      (LEVEL_BITS),
        .DECAY_FRAC_BITS (DECAY_FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_empty      (w_q_empty),
        .i_q_data       (w_q_rdata),
        .o_q_pop        (w_q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_post_current (o_post_current),
        .o_conductance  (o_conductance)
    );

    assign full = w_q_full;

endmodule

`default_nettype wire
